// ----- design/thbe_pkg.sv -----
// Shared types and constants of the thresholded binary erosion block.
package thbe_pkg;

    // Field and register widths fixed by the block's register map
    localparam int PIX_W      = 8;
    localparam int THR_W      = 8;
    localparam int MASK_W     = 49;
    localparam int RLEN_W     = 11;
    localparam int CFG_DATA_W = 49;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH   = 2'd2;

    // Register reset values
    localparam logic [THR_W-1:0]  THRESHOLD_RESET  = 8'd128;
    localparam logic [RLEN_W-1:0] ROW_LENGTH_RESET = 11'd1024;

    // Output pixel levels
    localparam logic [PIX_W-1:0] PIX_SET   = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_CLEAR = 8'h00;

    // Position flags of one pixel, worked out when it is accepted
    typedef struct packed {
        logic valid;   // full window lies inside the frame
        logic last;    // last pixel of its row
    } t_pos_flags;

endpackage

// ----- design/thbe_counters.sv -----
// Column and row counters of the erosion block, with window validity flags.
module thbe_counters #(
    parameter int EXTENT  = 3,
    parameter int MAX_ROW = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_frame_start,
    input  logic [$clog2(MAX_ROW)-1:0] i_len_m1,
    output logic [$clog2(MAX_ROW)-1:0] o_col,
    output thbe_pkg::t_pos_flags       o_flags
);

    localparam int COL_W = $clog2(MAX_ROW);
    localparam int HIST  = 2 * EXTENT;
    localparam int RS_W  = $clog2(HIST + 1);

    logic [COL_W-1:0] r_col, n_col;
    logic [RS_W-1:0]  r_rows, n_rows;
    logic [RS_W-1:0]  rows_now;
    logic             last;

    // Clear both counters ahead of the first pixel of a frame
    always_comb begin
        o_col    = i_frame_start ? '0 : r_col;
        rows_now = i_frame_start ? '0 : r_rows;
        last     = (o_col >= i_len_m1);
        o_flags.last  = last;
        o_flags.valid = (rows_now == RS_W'(HIST)) && (o_col >= COL_W'(HIST));
        n_col  = last ? '0 : o_col + COL_W'(1);
        n_rows = (last && (rows_now != RS_W'(HIST))) ? rows_now + RS_W'(1) : rows_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_rows <= '0;
        end else if (i_accept) begin
            r_col  <= n_col;
            r_rows <= n_rows;
        end
    end

endmodule

// ----- design/thbe_line_store.sv -----
// Column history memory: one read and one write a cycle, registered read, write bypass.
module thbe_line_store #(
    parameter int EXTENT  = 3,
    parameter int MAX_ROW = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [$clog2(MAX_ROW)-1:0] i_rd_addr,
    input  logic                       i_wr_en,
    input  logic [$clog2(MAX_ROW)-1:0] i_wr_addr,
    input  logic [2*EXTENT-1:0]        i_wr_data,
    output logic [2*EXTENT-1:0]        o_rd_data
);

    localparam int HIST = 2 * EXTENT;

    logic [HIST-1:0] r_mem [MAX_ROW];
    logic [HIST-1:0] r_rd_data;
    logic [HIST-1:0] r_fwd_data;
    logic            r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // Take the word being written when a read hits the same address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule

// ----- design/thbe_window.sv -----
// Binary window shift register and structuring-element match.
module thbe_window #(
    parameter int EXTENT = 3
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_shift,
    input  logic [2*EXTENT:0]                         i_column,
    input  logic [(2*EXTENT+1)*(2*EXTENT+1)-1:0]      i_mask,
    output logic                                      o_match
);

    localparam int WIN_SIDE = 2 * EXTENT + 1;
    localparam int WIN_BITS = WIN_SIDE * WIN_SIDE;

    logic [WIN_BITS-1:0] r_window, n_window;

    // Shift each window row one column left, new column enters at the top bit
    always_comb begin
        for (int y = 0; y < WIN_SIDE; y++) begin
            n_window[y*WIN_SIDE +: WIN_SIDE] =
                {i_column[y], r_window[y*WIN_SIDE+1 +: WIN_SIDE-1]};
        end
        o_match = ((n_window & i_mask) == i_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (i_shift) begin
            r_window <= n_window;
        end
    end

endmodule

// ----- design/threshold_binary_erosion_top.sv -----
// Top level of the thresholded binary erosion block: registers, pipeline and handshakes.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one gray pixel of a border-extended
//   image per transaction, in raster order, with i_frame_start on the first pixel.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result transaction per
//   input pixel: o_eroded_pixel (0 or 255), o_result_valid and o_row_end.
//   Configuration is a plain write port (i_cfg_wr_en, i_cfg_index, i_cfg_data): index 0
//   threshold, 1 structuring-element mask, 2 row length. Write only while the block is idle.
// Timing:
//   A pixel accepted into the input stage lands in the output register when that register
//   is free; throughput is one pixel per clock while i_out_ready stays high. The figure is
//   set by the line store, one read and one write of the same column history each cycle,
//   and by the two-register pipeline (input stage with registered memory read, result register).
// Reset:
//   Counters, window and pipeline valids clear; registers return to threshold 128, centre-only
//   mask and row length 1024. The line store is not cleared: a valid result only uses entries
//   written in the current frame, so no clearing pass runs and the block is ready at once.
// Stall:
//   With i_out_ready low the result holds; the input stage still takes one more pixel and
//   then o_in_ready drops until the output register drains.
module threshold_binary_erosion_top #(
    parameter int EXTENT  = 3,
    parameter int MAX_ROW = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [thbe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [thbe_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [thbe_pkg::PIX_W-1:0]          i_gray_pixel,
    input  logic                                i_frame_start,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [thbe_pkg::PIX_W-1:0]          o_eroded_pixel,
    output logic                                o_result_valid,
    output logic                                o_row_end
);

    localparam int COL_W    = $clog2(MAX_ROW);
    localparam int HIST     = 2 * EXTENT;
    localparam int WIN_SIDE = 2 * EXTENT + 1;
    localparam int WIN_BITS = WIN_SIDE * WIN_SIDE;
    localparam int CENTRE   = EXTENT * WIN_SIDE + EXTENT;
    localparam int LEN_W    = (COL_W + 1 > thbe_pkg::RLEN_W) ? COL_W + 1 : thbe_pkg::RLEN_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [thbe_pkg::THR_W-1:0]  r_threshold;
    logic [thbe_pkg::MASK_W-1:0] r_element_mask;
    logic [thbe_pkg::RLEN_W-1:0] r_row_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= thbe_pkg::THRESHOLD_RESET;
            r_element_mask <= thbe_pkg::MASK_W'(1) << CENTRE;
            r_row_length   <= thbe_pkg::ROW_LENGTH_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                thbe_pkg::CFG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[thbe_pkg::THR_W-1:0];
                end
                thbe_pkg::CFG_ELEMENT_MASK: begin
                    r_element_mask <= i_cfg_data[thbe_pkg::MASK_W-1:0];
                end
                thbe_pkg::CFG_ROW_LENGTH: begin
                    r_row_length <= i_cfg_data[thbe_pkg::RLEN_W-1:0];
                end
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // Clamp the row length to one window side at least and to the line store depth at most
    logic [LEN_W-1:0] len_ext, len_eff;
    logic [COL_W-1:0] len_m1;

    always_comb begin
        len_ext = LEN_W'(r_row_length);
        if (len_ext < LEN_W'(WIN_SIDE)) begin
            len_eff = LEN_W'(WIN_SIDE);
        end else if (len_ext > LEN_W'(MAX_ROW)) begin
            len_eff = LEN_W'(MAX_ROW);
        end else begin
            len_eff = len_ext;
        end
        len_m1 = COL_W'(len_eff - LEN_W'(1));
    end

    // ------------------------------------------------------------------
    // Handshake: input stage, then result register
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic in_accept;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Accept: counters, threshold and line store read
    // ------------------------------------------------------------------
    logic [COL_W-1:0]     col;
    thbe_pkg::t_pos_flags pos_flags;

    thbe_counters #(
        .EXTENT  (EXTENT),
        .MAX_ROW (MAX_ROW)
    ) u_counters (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_frame_start (i_frame_start),
        .i_len_m1      (len_m1),
        .o_col         (col),
        .o_flags       (pos_flags)
    );

    logic                 r_s1_bit;
    logic [COL_W-1:0]     r_s1_col;
    thbe_pkg::t_pos_flags r_s1_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Hold the stage payload until the next pixel enters
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_bit   <= (i_gray_pixel >= r_threshold);
            r_s1_col   <= col;
            r_s1_flags <= pos_flags;
        end
    end

    // ------------------------------------------------------------------
    // Advance: build the column, write back the history, shift the window
    // ------------------------------------------------------------------
    logic [HIST-1:0]     stored;
    logic [WIN_SIDE-1:0] column;
    logic                match;

    thbe_line_store #(
        .EXTENT  (EXTENT),
        .MAX_ROW (MAX_ROW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (col),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (column[WIN_SIDE-1:1]),
        .o_rd_data (stored)
    );

    // Newest bit on top; drop the oldest row on write-back
    assign column = {r_s1_bit, stored};

    thbe_window #(
        .EXTENT (EXTENT)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (s1_adv),
        .i_column (column),
        .i_mask   (r_element_mask[WIN_BITS-1:0]),
        .o_match  (match)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [thbe_pkg::PIX_W-1:0] r_eroded_pixel;
    logic                       r_result_valid;
    logic                       r_row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Force value and row end to zero outside a full window
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_eroded_pixel <= (r_s1_flags.valid && match) ? thbe_pkg::PIX_SET
                                                          : thbe_pkg::PIX_CLEAR;
            r_result_valid <= r_s1_flags.valid;
            r_row_end      <= r_s1_flags.valid && r_s1_flags.last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_eroded_pixel = r_eroded_pixel;
    assign o_result_valid = r_result_valid;
    assign o_row_end      = r_row_end;

`ifndef NO_ASSERTIONS
    // A full input stage behind a stalled result register must block the input
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while both pipeline stages are held");

    // The first pixel of a frame can never see a full window
    a_frame_start_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_frame_start) |=> !r_s1_flags.valid)
        else $error("frame start pixel flagged with a full window");

    // Outside a full window the result carries neither value nor row end
    a_invalid_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_result_valid) |->
            (o_eroded_pixel == thbe_pkg::PIX_CLEAR) && !o_row_end)
        else $error("invalid result carries a pixel value or row end");

    // A result can only enter the output register from a full input stage
    a_result_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_valid && !r_out_valid) |=> !r_out_valid)
        else $error("result appeared without a pixel in the input stage");
`endif

endmodule

// ----- bench/erosion_bench_pkg.sv -----
// Erosion predictor and result scoreboard used by the erosion block testbench.
package erosion_bench_pkg;
    import thbe_pkg::*;

    localparam int EXTENT     = 3;
    localparam int WIN_SIDE   = 2 * EXTENT + 1;
    localparam int WIN_BITS   = WIN_SIDE * WIN_SIDE;
    localparam int HIST_ROWS  = 2 * EXTENT;
    localparam int MAX_ROW    = 1024;
    localparam int CENTRE_BIT = EXTENT * WIN_SIDE + EXTENT;

    typedef struct packed {
        logic [PIX_W-1:0] eroded_pixel;
        logic             result_valid;
        logic             row_end;
    } t_erosion_result;

    class erosion_scoreboard;
        logic [THR_W-1:0]     threshold;
        logic [MASK_W-1:0]    element_mask;
        logic [RLEN_W-1:0]    row_length;
        logic [HIST_ROWS-1:0] column_history [MAX_ROW];
        logic [WIN_BITS-1:0]  window_bits;
        int unsigned          column_count;
        int unsigned          rows_seen;
        t_erosion_result      pending_erosions [$];
        int unsigned          results_seen;
        int unsigned          mismatch_count;

        function new();
            threshold    = THRESHOLD_RESET;
            element_mask = MASK_W'(1) << CENTRE_BIT;
            row_length   = ROW_LENGTH_RESET;
            foreach (column_history[i]) column_history[i] = '0;
            window_bits    = '0;
            column_count   = 0;
            rows_seen      = 0;
            results_seen   = 0;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_THRESHOLD:    threshold    = data[THR_W-1:0];
                CFG_ELEMENT_MASK: element_mask = data[MASK_W-1:0];
                CFG_ROW_LENGTH:   row_length   = data[RLEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned effective_length();
            if (row_length < WIN_SIDE) return WIN_SIDE;
            if (row_length > MAX_ROW) return MAX_ROW;
            return row_length;
        endfunction

        function int unsigned pending();
            return pending_erosions.size();
        endfunction

        function void erode_pixel(logic [PIX_W-1:0] gray, logic frame_start);
            int unsigned          len;
            int unsigned          col;
            logic [WIN_SIDE-1:0]  column;
            logic [WIN_BITS-1:0]  shifted;
            logic                 row_last;
            logic                 in_frame;
            t_erosion_result      res;
            len = effective_length();
            if (frame_start) begin
                column_count = 0;
                rows_seen    = 0;
            end
            col = (column_count >= MAX_ROW) ? MAX_ROW - 1 : column_count;
            // newest bit on top of the stored column history
            column = {gray >= threshold, column_history[col]};
            column_history[col] = column[WIN_SIDE-1:1];
            for (int y = 0; y < WIN_SIDE; y++) begin
                shifted[y*WIN_SIDE +: WIN_SIDE] =
                    {column[y], window_bits[y*WIN_SIDE+1 +: WIN_SIDE-1]};
            end
            window_bits = shifted;
            row_last = column_count >= len - 1;
            in_frame = rows_seen >= HIST_ROWS && column_count >= HIST_ROWS;
            res.result_valid = in_frame;
            res.eroded_pixel = (in_frame && (window_bits & element_mask) == element_mask)
                               ? PIX_SET : PIX_CLEAR;
            res.row_end      = in_frame && row_last;
            pending_erosions.push_back(res);
            if (row_last) begin
                column_count = 0;
                if (rows_seen < HIST_ROWS) rows_seen++;
            end else begin
                column_count++;
            end
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("MISMATCH: %s", what);
        endtask

        task check_result(logic [PIX_W-1:0] eroded_pixel, logic result_valid, logic row_end);
            t_erosion_result want;
            results_seen++;
            if (pending_erosions.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no pixel outstanding",
                                          results_seen));
                return;
            end
            want = pending_erosions.pop_front();
            if (eroded_pixel !== want.eroded_pixel)
                report_mismatch($sformatf("result %0d eroded_pixel got %0d want %0d",
                                          results_seen, eroded_pixel, want.eroded_pixel));
            if (result_valid !== want.result_valid)
                report_mismatch($sformatf("result %0d result_valid got %0b want %0b",
                                          results_seen, result_valid, want.result_valid));
            if (row_end !== want.row_end)
                report_mismatch($sformatf("result %0d row_end got %0b want %0b",
                                          results_seen, row_end, want.row_end));
        endtask
    endclass

endpackage

// ----- bench/testbench.sv -----
// Top-level testbench of the thresholded binary erosion block: stimulus, pacing and checking.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import thbe_pkg::*;
    import erosion_bench_pkg::*;

    // Run bounds: a timeout far above the slowest legal run, the random stimulus size and
    // the quiet spell after the last result before a register write or the end.
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_ITEMS  = 720;
    localparam int unsigned SETTLE_CYCLES = 8;

    // Register index that maps to nothing; a write there must leave every register alone
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum int {
        MASK_EMPTY, MASK_FULL, MASK_CENTRE, MASK_CROSS, MASK_SQUARE, MASK_SPARSE, MASK_RANDOM
    } t_mask_kind;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_PERIODIC} t_stall_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [PIX_W-1:0]      i_gray_pixel;
    logic                  i_frame_start;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [PIX_W-1:0]      o_eroded_pixel;
    logic                  o_result_valid;
    logic                  o_row_end;

    erosion_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int unsigned pixels_sent = 0;
    int unsigned burst_left  = 0;
    bit          no_gaps     = 1'b0;

    threshold_binary_erosion_top #(
        .EXTENT  (EXTENT),
        .MAX_ROW (MAX_ROW)
    ) DUT (.*);

    // Clock: 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: count cycles and abandon the run once the limit is reached
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
                 sb.pending());
        $display("Some tests failed");
        $finish;
    end

    // Result monitor: sample each output transaction at the rising edge and hand it to
    // the scoreboard, which compares it with the oldest outstanding erosion.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1)
            sb.check_result(o_eroded_pixel, o_result_valid, o_row_end);
    end

    // Receiver: stall on its own pattern. Switch between always ready, coin flips, rare
    // stalls and a periodic stall every so often. Hold off for a long stretch at least
    // once while pixels are on offer, so that the block fills and drops o_in_ready.
    initial begin : receiver
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned period;
        t_stall_mode mode;
        bit          long_hold_done;
        logic        ready;
        i_out_ready    = 1'b0;
        mode_left      = 0;
        hold_left      = 0;
        period         = 2;
        mode           = READY_ALWAYS;
        long_hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && i_in_valid &&
                ((!long_hold_done && pixels_sent > 300) || $urandom_range(2999, 0) == 0)) begin
                hold_left      = $urandom_range(300, 120);
                long_hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(3, 0));
                period    = $urandom_range(5, 2);
                mode_left = $urandom_range(200, 20);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                ready = 1'b0;
            end else begin
                case (mode)
                    READY_ALWAYS: ready = 1'b1;
                    READY_COIN:   ready = 1'($urandom_range(1, 0));
                    READY_MOSTLY: ready = $urandom_range(7, 0) != 0;
                    default:      ready = (cycle_count % period) != 0;
                endcase
            end
            i_out_ready <= ready;
        end
    end

    function automatic logic [CFG_DATA_W-1:0] rand49();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[CFG_DATA_W-1:0];
    endfunction

    // Fill the unused bits above a register's width with junk half the time
    function automatic logic [CFG_DATA_W-1:0] with_spare(logic [CFG_DATA_W-1:0] value,
                                                         int width);
        logic [CFG_DATA_W-1:0] junk;
        logic [CFG_DATA_W-1:0] keep;
        junk = $urandom_range(1, 0) ? rand49() : '0;
        keep = (CFG_DATA_W'(1) << width) - 1;
        return (junk & ~keep) | (value & keep);
    endfunction

    function automatic logic [MASK_W-1:0] build_mask(t_mask_kind kind);
        logic [MASK_W-1:0] m;
        m = '0;
        case (kind)
            MASK_EMPTY:  m = '0;
            MASK_FULL:   m = '1;
            MASK_CENTRE: m[CENTRE_BIT] = 1'b1;
            MASK_CROSS: begin
                for (int k = 0; k < WIN_SIDE; k++) begin
                    m[k*WIN_SIDE + EXTENT] = 1'b1;
                    m[EXTENT*WIN_SIDE + k] = 1'b1;
                end
            end
            MASK_SQUARE: begin
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++)
                        m[CENTRE_BIT + dy*WIN_SIDE + dx] = 1'b1;
            end
            MASK_SPARSE: begin
                repeat ($urandom_range(4, 1)) m[$urandom_range(WIN_BITS-1, 0)] = 1'b1;
            end
            default: m = rand49();
        endcase
        return m;
    endfunction

    // Gray level that lands on the wanted side of the threshold; hit the edge itself often
    function automatic logic [PIX_W-1:0] pick_gray(bit want_set, logic [THR_W-1:0] thr);
        if ($urandom_range(7, 0) == 0)
            return (want_set || thr == 0) ? thr : thr - 8'd1;
        if (want_set || thr == 0)
            return PIX_W'($urandom_range(255, thr));
        return PIX_W'($urandom_range(thr - 1, 0));
    endfunction

    function automatic logic [THR_W-1:0] pick_threshold();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return '1;
            default: return THR_W'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic logic [RLEN_W-1:0] pick_length();
        if ($urandom_range(7, 0) == 0) return RLEN_W'($urandom_range(WIN_SIDE - 1, 0));
        if ($urandom_range(15, 0) == 0) return RLEN_W'($urandom_range(60, 25));
        return RLEN_W'($urandom_range(24, WIN_SIDE));
    endfunction

    function automatic int pick_fill();
        case ($urandom_range(4, 0))
            0:       return 50;
            1:       return 85;
            2:       return 95;
            3:       return 99;
            default: return 100;
        endcase
    endfunction

    // Drop valid while the sender idles
    task idle_cycles(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // Sender pacing: bursts of random length, random gaps between them
    task pace();
        int unsigned gap;
        if (burst_left == 0) begin
            gap = (no_gaps || $urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            idle_cycles(gap);
            burst_left = $urandom_range(40, 1);
        end
        burst_left--;
    endtask

    // Offer one pixel and hold it until the transaction completes
    task send_pixel(input logic [PIX_W-1:0] gray, input logic frame_start);
        pace();
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_gray_pixel  <= gray;
        i_frame_start <= frame_start;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.erode_pixel(gray, frame_start);
        pixels_sent++;
    endtask

    task drive_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        sb.write_reg(index, data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Wait until every outstanding result has drained, then leave the block quiet a while
    task settle();
        idle_cycles(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One phase: reconfigure while idle, then stream rows of thresholded content.
    // frame_mode 0: start a new frame at random, 1: always, 2: carry on the current frame.
    // Carry on only when the effective row length does not grow, so that every line store
    // column a valid window reads has been written in the current frame.
    task run_phase(input logic [THR_W-1:0] thr, input logic [MASK_W-1:0] mask,
                   input logic [RLEN_W-1:0] len, input int rows, input int extra,
                   input int fill, input int frame_mode);
        int unsigned prev_len;
        int unsigned total;
        int          break_at;
        bit          new_frame;
        settle();
        prev_len = sb.effective_length();
        drive_reg(CFG_THRESHOLD, with_spare(CFG_DATA_W'(thr), THR_W));
        drive_reg(CFG_ELEMENT_MASK, CFG_DATA_W'(mask));
        drive_reg(CFG_ROW_LENGTH, with_spare(CFG_DATA_W'(len), RLEN_W));
        new_frame = sb.effective_length() > prev_len || frame_mode == 1 ||
                    (frame_mode == 0 && $urandom_range(1, 0) == 1);
        no_gaps   = $urandom_range(3, 0) == 0;
        total     = rows * sb.effective_length() + extra;
        // now and then abandon the frame part way through with a fresh frame start
        break_at  = (frame_mode == 0 && $urandom_range(4, 0) == 0)
                    ? int'($urandom_range(total - 1, 1)) : -1;
        for (int i = 0; i < total; i++)
            send_pixel(pick_gray($urandom_range(100, 1) <= fill, thr),
                       (i == 0 && new_frame) || i == break_at);
    endtask

    // Noise: arbitrary gray levels with scattered frame starts, configuration untouched
    task run_noise(input int unsigned count);
        no_gaps = 1'b0;
        repeat (count)
            send_pixel(PIX_W'($urandom_range(255, 0)), $urandom_range(29, 0) == 0);
    endtask

    initial begin : stimulus
        int unsigned target;
        // drive every input to a known level from time zero
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_THRESHOLD;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_gray_pixel  = '0;
        i_frame_start = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels under reset configuration: gray extremes, both sides of the
        // threshold and frame starts inside a row. No window is full yet, so every
        // result must come back invalid with row_end low.
        send_pixel(8'd0,   1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd127, 1'b0);
        send_pixel(8'd129, 1'b0);
        send_pixel(8'hAA,  1'b0);
        send_pixel(8'h55,  1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd1,   1'b0);
        send_pixel(8'd254, 1'b1);
        send_pixel(8'd0,   1'b1);
        send_pixel(8'd128, 1'b0);

        // Shortest legal row, centre-only element
        run_phase(8'd128, build_mask(MASK_CENTRE), 11'd7, 9, 3, 50, 1);
        // Empty element gives a set result at every full window; a zero length acts as the minimum
        run_phase(8'd255, build_mask(MASK_EMPTY), 11'd0, 7, 0, 30, 1);
        // Zero threshold sets every pixel, full element; length below the minimum
        run_phase(8'd0, build_mask(MASK_FULL), 11'd3, 8, 2, 50, 1);
        // Full element over almost solid content, one short of the minimum length
        run_phase(8'd200, build_mask(MASK_FULL), 11'd6, 9, 0, 98, 1);
        // Stop mid-row, then lower the row length and carry on the same frame: the row in
        // progress ends with its next pixel, whose column already lies past the new length
        run_phase(8'd128, build_mask(MASK_CROSS), 11'd20, 7, 15, 90, 1);
        run_phase(8'd128, build_mask(MASK_SQUARE), 11'd8, 8, 0, 90, 2);
        // Longest row: anything above the maximum acts as the maximum, so a short
        // stretch of pixels ends no row
        run_phase(8'd100, build_mask(MASK_CROSS), 11'd2047, 0, 30, 95, 1);
        // A write to the unused index must leave the configuration alone
        settle();
        drive_reg(CFG_UNUSED_INDEX, rand49());
        run_noise(40);

        // Random phases: mostly well-formed frames with random content and settings,
        // the rest noise
        target = pixels_sent + RANDOM_ITEMS;
        while (pixels_sent < target) begin
            if ($urandom_range(5, 0) == 0)
                run_noise($urandom_range(100, 20));
            else
                run_phase(pick_threshold(), build_mask(t_mask_kind'($urandom_range(6, 0))),
                          pick_length(), $urandom_range(10, 7), $urandom_range(12, 0),
                          pick_fill(), 0);
        end

        // Drain every outstanding result, then give any stray one time to show
        settle();
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
